/* hw/rtl/inns_pkg.sv */
// ----------------------------------------------------------------------------
// inns_pkg
// Shared types, constants and helpers for the nearest-neighbour scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package inns_pkg;

    // Scaling and frame limits.
    localparam int MAX_STEP   = 8;
    localparam int MAX_DIM    = 4096;
    localparam int STEP_W     = 4;
    localparam int PHASE_W    = $clog2(MAX_STEP);
    localparam int DIM_W      = 13;
    localparam int POS_W      = $clog2(MAX_DIM);
    localparam int DEST_W     = 15;
    localparam int CH_W       = 8;
    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    // Depth of the command queue between the front and back ends.
    localparam int QUEUE_DEPTH = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DIM_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENLARGE      = 3'd0,
        REG_X_STEP       = 3'd1,
        REG_Y_STEP       = 3'd2,
        REG_BINARIZE     = 3'd3,
        REG_THRESHOLD    = 3'd4,
        REG_FRAME_WIDTH  = 3'd5,
        REG_FRAME_HEIGHT = 3'd6
    } t_reg_idx;

    // Register contents as written.
    typedef struct packed {
        logic              enlarge;
        logic [STEP_W-1:0] x_step;
        logic [STEP_W-1:0] y_step;
        logic              binarize;
        logic [CH_W-1:0]   threshold;
        logic [DIM_W-1:0]  frame_width;
        logic [DIM_W-1:0]  frame_height;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        enlarge:      1'b0,
        x_step:       4'd2,
        y_step:       4'd2,
        binarize:     1'b0,
        threshold:    8'd127,
        frame_width:  13'd640,
        frame_height: 13'd480
    };

    // One tile to emit: shrink results are a one by one tile.
    typedef struct packed {
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
        logic [DEST_W-1:0]  base_x;
        logic [DEST_W-1:0]  base_y;
        logic [PHASE_W-1:0] ws_m1;
        logic [PHASE_W-1:0] hs_m1;
    } t_cmd;

    // A step of zero acts as one, a step above the maximum as the maximum.
    function automatic logic [STEP_W-1:0] clamp_step(input logic [STEP_W-1:0] v);
        logic [STEP_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = STEP_W'(1);
        end else if (v > STEP_W'(MAX_STEP)) begin
            res = STEP_W'(MAX_STEP);
        end
        return res;
    endfunction

    // A frame size of zero acts as one, one above the maximum as the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/integer_nearest_neighbor_scaler.sv */
// ----------------------------------------------------------------------------
// integer_nearest_neighbor_scaler
// Streaming nearest-neighbour scaler for raster-order RGB pixels.
// ----------------------------------------------------------------------------
// In shrink mode the block takes one pixel per cycle while full is low and
// gives at most one result for it; in enlarge mode each pixel gives the
// horizontal step times the vertical step results, one per cycle while the
// result register is free or popped. Pixels are classified on arrival and
// queued as tile commands in a four-entry queue, so the input keeps flowing
// while a tile is emitted, and full rises only when that queue is full.
// With the back end idle, a pixel's first result passes the command queue
// and then the result register on its way to the output ports.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_nearest_neighbor_scaler (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Pixel input.
    input  wire                               push,
    output logic                              full,
    input  wire [inns_pkg::CH_W-1:0]          i_red,
    input  wire [inns_pkg::CH_W-1:0]          i_green,
    input  wire [inns_pkg::CH_W-1:0]          i_blue,
    // Result output.
    output logic                              empty,
    input  wire                               pop,
    output logic [inns_pkg::CH_W-1:0]         o_out_red,
    output logic [inns_pkg::CH_W-1:0]         o_out_green,
    output logic [inns_pkg::CH_W-1:0]         o_out_blue,
    output logic [inns_pkg::DEST_W-1:0]       o_dest_x,
    output logic [inns_pkg::DEST_W-1:0]       o_dest_y,
    output logic                              o_run_last,
    // Configuration writes.
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [inns_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [inns_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    inns_pkg::t_cfg r_cfg;
    inns_pkg::t_cmd wr_cmd, rd_cmd;
    logic           accept, wr_en, cmd_done, cmd_valid, out_valid;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;
    assign empty       = !out_valid;

    // Configuration registers; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= inns_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            case (inns_pkg::t_reg_idx'(i_cfg_index))
                inns_pkg::REG_ENLARGE:      r_cfg.enlarge      <= i_cfg_data[0];
                inns_pkg::REG_X_STEP:       r_cfg.x_step       <= i_cfg_data[3:0];
                inns_pkg::REG_Y_STEP:       r_cfg.y_step       <= i_cfg_data[3:0];
                inns_pkg::REG_BINARIZE:     r_cfg.binarize     <= i_cfg_data[0];
                inns_pkg::REG_THRESHOLD:    r_cfg.threshold    <= i_cfg_data[7:0];
                inns_pkg::REG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data;
                inns_pkg::REG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front end: position tracking and classification.
    inns_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (accept),
        .i_red    (i_red),
        .i_green  (i_green),
        .i_blue   (i_blue),
        .o_wr_en  (wr_en),
        .o_cmd    (wr_cmd)
    );

    // Command queue.
    inns_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_cmd   (wr_cmd),
        .i_rd_en    (cmd_done),
        .o_rd_cmd   (rd_cmd),
        .o_full     (full),
        .o_nonempty (cmd_valid)
    );

    // Back end: tile expansion and result register.
    inns_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (rd_cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_done  (cmd_done),
        .i_pop       (pop),
        .o_valid     (out_valid),
        .o_red       (o_out_red),
        .o_green     (o_out_green),
        .o_blue      (o_out_blue),
        .o_dest_x    (o_dest_x),
        .o_dest_y    (o_dest_y),
        .o_run_last  (o_run_last)
    );

endmodule

`default_nettype wire

/* hw/rtl/inns_front.sv */
// ----------------------------------------------------------------------------
// inns_front
// Tracks the raster position of each accepted pixel, applies the threshold
// if binarize is set and makes a tile command, or drops it in shrink mode.
// ----------------------------------------------------------------------------
`default_nettype none

module inns_front (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire inns_pkg::t_cfg         i_cfg,
    input  wire                         i_accept,
    input  wire [inns_pkg::CH_W-1:0]    i_red,
    input  wire [inns_pkg::CH_W-1:0]    i_green,
    input  wire [inns_pkg::CH_W-1:0]    i_blue,
    output logic                        o_wr_en,
    output inns_pkg::t_cmd              o_cmd
);

    logic [inns_pkg::POS_W-1:0]   r_column, n_column;
    logic [inns_pkg::POS_W-1:0]   r_row, n_row;
    logic [inns_pkg::PHASE_W-1:0] r_col_phase, n_col_phase;
    logic [inns_pkg::PHASE_W-1:0] r_row_phase, n_row_phase;
    logic [inns_pkg::POS_W-1:0]   r_col_block, n_col_block;
    logic [inns_pkg::POS_W-1:0]   r_row_block, n_row_block;

    logic [inns_pkg::STEP_W-1:0]  ws, hs;
    logic [inns_pkg::DIM_W-1:0]   fw, fh;
    logic                         corner, fits_x, fits_y;
    logic [16:0]                  span_x, span_y;
    logic [15:0]                  tile_x, tile_y;

    // Effective factors and frame size.
    assign ws = inns_pkg::clamp_step(i_cfg.x_step);
    assign hs = inns_pkg::clamp_step(i_cfg.y_step);
    assign fw = inns_pkg::clamp_dim(i_cfg.frame_width);
    assign fh = inns_pkg::clamp_dim(i_cfg.frame_height);

    // A block fits when its far edge, (index + 1) * step, is inside the frame.
    assign span_x = 17'((13'(r_col_block) + 13'd1) * 17'(ws));
    assign span_y = 17'((13'(r_row_block) + 13'd1) * 17'(hs));
    assign fits_x = span_x <= 17'(fw);
    assign fits_y = span_y <= 17'(fh);
    assign corner = (r_col_phase == '0) && (r_row_phase == '0);

    // Destination of the top-left pixel of an enlarged tile.
    assign tile_x = 16'(r_column) * 16'(ws);
    assign tile_y = 16'(r_row) * 16'(hs);

    // Thresholding of one channel.
    function automatic logic [inns_pkg::CH_W-1:0] chan(
        input logic [inns_pkg::CH_W-1:0] v,
        input inns_pkg::t_cfg           c
    );
        logic [inns_pkg::CH_W-1:0] res;
        res = v;
        if (c.binarize) begin
            res = (v > c.threshold) ? inns_pkg::CH_MAX : '0;
        end
        return res;
    endfunction

    // Command built from the current pixel.
    always_comb begin
        o_cmd.red   = chan(i_red, i_cfg);
        o_cmd.green = chan(i_green, i_cfg);
        o_cmd.blue  = chan(i_blue, i_cfg);
        if (i_cfg.enlarge) begin
            o_cmd.base_x = tile_x[inns_pkg::DEST_W-1:0];
            o_cmd.base_y = tile_y[inns_pkg::DEST_W-1:0];
            o_cmd.ws_m1  = inns_pkg::PHASE_W'(ws - 4'd1);
            o_cmd.hs_m1  = inns_pkg::PHASE_W'(hs - 4'd1);
        end else begin
            o_cmd.base_x = inns_pkg::DEST_W'(r_col_block);
            o_cmd.base_y = inns_pkg::DEST_W'(r_row_block);
            o_cmd.ws_m1  = '0;
            o_cmd.hs_m1  = '0;
        end
        o_wr_en = i_accept && (i_cfg.enlarge || (corner && fits_x && fits_y));
    end

    // Advance of position, phase and block index.
    always_comb begin
        n_column    = r_column;
        n_row       = r_row;
        n_col_phase = r_col_phase;
        n_row_phase = r_row_phase;
        n_col_block = r_col_block;
        n_row_block = r_row_block;
        if (i_accept) begin
            if ((13'(r_column) + 13'd1) >= fw) begin
                n_column    = '0;
                n_col_phase = '0;
                n_col_block = '0;
                if ((13'(r_row) + 13'd1) >= fh) begin
                    n_row       = '0;
                    n_row_phase = '0;
                    n_row_block = '0;
                end else begin
                    n_row = r_row + 1'b1;
                    if ((4'(r_row_phase) + 4'd1) >= hs) begin
                        n_row_phase = '0;
                        n_row_block = r_row_block + 1'b1;
                    end else begin
                        n_row_phase = r_row_phase + 1'b1;
                    end
                end
            end else begin
                n_column = r_column + 1'b1;
                if ((4'(r_col_phase) + 4'd1) >= ws) begin
                    n_col_phase = '0;
                    n_col_block = r_col_block + 1'b1;
                end else begin
                    n_col_phase = r_col_phase + 1'b1;
                end
            end
        end
    end

    // Position state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_row       <= '0;
            r_col_phase <= '0;
            r_row_phase <= '0;
            r_col_block <= '0;
            r_row_block <= '0;
        end else begin
            r_column    <= n_column;
            r_row       <= n_row;
            r_col_phase <= n_col_phase;
            r_row_phase <= n_row_phase;
            r_col_block <= n_col_block;
            r_row_block <= n_row_block;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/inns_queue.sv */
// ----------------------------------------------------------------------------
// inns_queue
// Short first-in first-out queue of tile commands between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module inns_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_wr_en,
    input  wire inns_pkg::t_cmd i_wr_cmd,
    input  wire                 i_rd_en,
    output inns_pkg::t_cmd      o_rd_cmd,
    output logic                o_full,
    output logic                o_nonempty
);

    localparam int PTR_W = $clog2(inns_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(inns_pkg::QUEUE_DEPTH + 1);

    inns_pkg::t_cmd   r_mem [inns_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full     = r_count == CNT_W'(inns_pkg::QUEUE_DEPTH);
    assign o_nonempty = r_count != '0;
    assign o_rd_cmd   = r_mem[r_rd_ptr];

    // Storage words.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_wr_en && !i_rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr_en && i_rd_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr_en && o_full))
        else $error("Command written into a full queue.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd_en && !o_nonempty))
        else $error("Command read from an empty queue.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(inns_pkg::QUEUE_DEPTH))
        else $error("Queue fill level beyond its depth.");
`endif

endmodule

`default_nettype wire

/* hw/rtl/inns_back.sv */
// ----------------------------------------------------------------------------
// inns_back
// Walks each tile command row by row into a result register that the consumer
// pops, one result word per cycle while that register is free or popped.
// ----------------------------------------------------------------------------
`default_nettype none

module inns_back (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire inns_pkg::t_cmd         i_cmd,
    input  wire                         i_cmd_valid,
    output logic                        o_cmd_done,
    input  wire                         i_pop,
    output logic                        o_valid,
    output logic [inns_pkg::CH_W-1:0]   o_red,
    output logic [inns_pkg::CH_W-1:0]   o_green,
    output logic [inns_pkg::CH_W-1:0]   o_blue,
    output logic [inns_pkg::DEST_W-1:0] o_dest_x,
    output logic [inns_pkg::DEST_W-1:0] o_dest_y,
    output logic                        o_run_last
);

    logic [inns_pkg::PHASE_W-1:0] r_l, r_k;
    logic                         r_valid;
    logic                         adv, last_l, last_k;

    // A new word is produced when the result register is free or being popped.
    assign adv        = i_cmd_valid && (!r_valid || i_pop);
    assign last_l     = r_l == i_cmd.ws_m1;
    assign last_k     = r_k == i_cmd.hs_m1;
    assign o_cmd_done = adv && last_l && last_k;
    assign o_valid    = r_valid;

    // Result word payload.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_red      <= i_cmd.red;
            o_green    <= i_cmd.green;
            o_blue     <= i_cmd.blue;
            o_dest_x   <= i_cmd.base_x + inns_pkg::DEST_W'(r_l);
            o_dest_y   <= i_cmd.base_y + inns_pkg::DEST_W'(r_k);
            o_run_last <= last_l && last_k;
        end
    end

    // Tile counters and result occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l     <= '0;
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_valid <= 1'b1;
                if (last_l) begin
                    r_l <= '0;
                    r_k <= last_k ? '0 : r_k + 1'b1;
                end else begin
                    r_l <= r_l + 1'b1;
                end
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_tile_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid |-> (r_l <= i_cmd.ws_m1 && r_k <= i_cmd.hs_m1))
        else $error("Tile counter beyond the tile size.");

    a_idle_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd_valid |-> (r_l == '0 && r_k == '0))
        else $error("Tile counters not at rest between commands.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_pop) |=> r_valid)
        else $error("Waiting result word dropped before it was popped.");
`endif

endmodule

`default_nettype wire

/* verif/inns_pixel_checker.sv */
// ----------------------------------------------------------------------------
// inns_pixel_checker
// Predicts and checks the scaled pixel stream of the nearest-neighbour scaler.
// ----------------------------------------------------------------------------
// Watches the pixel, result and register channels. Every accepted pixel word
// is run through a local model of the scaler, which queues the pixels that it
// should produce. Every accepted result word is compared field by field with
// the oldest queued pixel. Counts of mismatches and outstanding pixels are
// handed to the testbench top.
// ----------------------------------------------------------------------------
module inns_pixel_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic                            i_full,
    input  logic [inns_pkg::CH_W-1:0]       i_red,
    input  logic [inns_pkg::CH_W-1:0]       i_green,
    input  logic [inns_pkg::CH_W-1:0]       i_blue,
    input  logic                            i_empty,
    input  logic                            i_pop,
    input  logic [inns_pkg::CH_W-1:0]       i_out_red,
    input  logic [inns_pkg::CH_W-1:0]       i_out_green,
    input  logic [inns_pkg::CH_W-1:0]       i_out_blue,
    input  logic [inns_pkg::DEST_W-1:0]     i_dest_x,
    input  logic [inns_pkg::DEST_W-1:0]     i_dest_y,
    input  logic                            i_run_last,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [inns_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [inns_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_errors,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [inns_pkg::CH_W-1:0]   red;
        logic [inns_pkg::CH_W-1:0]   green;
        logic [inns_pkg::CH_W-1:0]   blue;
        logic [inns_pkg::DEST_W-1:0] dest_x;
        logic [inns_pkg::DEST_W-1:0] dest_y;
        logic                        last;
    } t_scaled_pixel;

    // Local copy of the registers and of the position tracking.
    inns_pkg::t_cfg regs = inns_pkg::CFG_RESET;
    logic [11:0]    col = '0;
    logic [11:0]    row_pos = '0;
    logic [2:0]     col_phase = '0;
    logic [2:0]     row_phase = '0;
    logic [11:0]    col_blk = '0;
    logic [11:0]    row_blk = '0;

    t_scaled_pixel expected_pixels[$];
    t_scaled_pixel want;
    int            errors = 0;
    int            pending_cnt = 0;

    assign o_errors  = errors;
    assign o_pending = pending_cnt;

    // Zero acts as one and anything above the ceiling acts as the ceiling.
    function automatic int effective(input int v, input int ceiling);
        if (v == 0) begin
            return 1;
        end
        return (v > ceiling) ? ceiling : v;
    endfunction

    // Optional thresholding of one channel.
    function automatic logic [inns_pkg::CH_W-1:0] level(input logic [inns_pkg::CH_W-1:0] v);
        if (!regs.binarize) begin
            return v;
        end
        return (v > regs.threshold) ? inns_pkg::CH_MAX : '0;
    endfunction

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
        end
    endtask

    // Work out the pixels caused by one input word and advance the position.
    task automatic scale_pixel(input logic [inns_pkg::CH_W-1:0] r_in, g_in, b_in);
        int            ws;
        int            hs;
        int            fw;
        int            fh;
        t_scaled_pixel px;
        ws = effective(int'(regs.x_step), inns_pkg::MAX_STEP);
        hs = effective(int'(regs.y_step), inns_pkg::MAX_STEP);
        fw = effective(int'(regs.frame_width), inns_pkg::MAX_DIM);
        fh = effective(int'(regs.frame_height), inns_pkg::MAX_DIM);
        px.red   = level(r_in);
        px.green = level(g_in);
        px.blue  = level(b_in);

        if (regs.enlarge) begin
            // The whole tile goes out row by row; the last word closes the run.
            for (int k = 0; k < hs; k++) begin
                for (int l = 0; l < ws; l++) begin
                    px.dest_x = inns_pkg::DEST_W'(int'(col) * ws + l);
                    px.dest_y = inns_pkg::DEST_W'(int'(row_pos) * hs + k);
                    px.last   = (k == hs - 1) && (l == ws - 1);
                    expected_pixels.push_back(px);
                end
            end
        end else if (col_phase == '0 && row_phase == '0 &&
                     int'(col_blk) < fw / ws && int'(row_blk) < fh / hs) begin
            // Only the corner of a block lying wholly inside the frame survives.
            px.dest_x = inns_pkg::DEST_W'(col_blk);
            px.dest_y = inns_pkg::DEST_W'(row_blk);
            px.last   = 1'b1;
            expected_pixels.push_back(px);
        end

        // A position at or past a reduced frame edge counts as the last one.
        if (int'(col) + 1 >= fw) begin
            col       = '0;
            col_phase = '0;
            col_blk   = '0;
            if (int'(row_pos) + 1 >= fh) begin
                row_pos   = '0;
                row_phase = '0;
                row_blk   = '0;
            end else begin
                row_pos++;
                if (int'(row_phase) + 1 >= hs) begin
                    row_phase = '0;
                    row_blk++;
                end else begin
                    row_phase++;
                end
            end
        end else begin
            col++;
            if (int'(col_phase) + 1 >= ws) begin
                col_phase = '0;
                col_blk++;
            end else begin
                col_phase++;
            end
        end
    endtask

    // Results are checked before new pixels are predicted in the same cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs      = inns_pkg::CFG_RESET;
            col       = '0;
            row_pos   = '0;
            col_phase = '0;
            row_phase = '0;
            col_blk   = '0;
            row_blk   = '0;
            expected_pixels.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_pixels.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word, expected none, actual x %0d y %0d",
                             $time, i_dest_x, i_dest_y);
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("out_red", want.red, i_out_red);
                    check_field("out_green", want.green, i_out_green);
                    check_field("out_blue", want.blue, i_out_blue);
                    check_field("dest_x", want.dest_x, i_dest_x);
                    check_field("dest_y", want.dest_y, i_dest_y);
                    check_field("run_last", want.last, i_run_last);
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    inns_pkg::REG_ENLARGE:
                        regs.enlarge      = i_cfg_data[0];
                    inns_pkg::REG_X_STEP:
                        regs.x_step       = i_cfg_data[inns_pkg::STEP_W-1:0];
                    inns_pkg::REG_Y_STEP:
                        regs.y_step       = i_cfg_data[inns_pkg::STEP_W-1:0];
                    inns_pkg::REG_BINARIZE:
                        regs.binarize     = i_cfg_data[0];
                    inns_pkg::REG_THRESHOLD:
                        regs.threshold    = i_cfg_data[inns_pkg::CH_W-1:0];
                    inns_pkg::REG_FRAME_WIDTH:
                        regs.frame_width  = i_cfg_data[inns_pkg::DIM_W-1:0];
                    inns_pkg::REG_FRAME_HEIGHT:
                        regs.frame_height = i_cfg_data[inns_pkg::DIM_W-1:0];
                    // An unknown index leaves every register alone.
                    default: ;
                endcase
            end

            if (i_push && !i_full) begin
                scale_pixel(i_red, i_green, i_blue);
            end
        end
        pending_cnt = expected_pixels.size();
    end

endmodule

/* verif/tb_integer_nearest_neighbor_scaler.sv */
// ----------------------------------------------------------------------------
// tb_integer_nearest_neighbor_scaler
// Stimulus and verdict for the nearest-neighbour scaler.
// ----------------------------------------------------------------------------
// A short directed sequence covers channel extremes, the largest tile, zero
// and oversized steps and frame sizes, an unknown register index, dropped
// edge blocks and settings changed part way through a frame. Random phases
// follow, each with fresh settings and a burst of pixel words. The sender
// idles in random bursts and the receiver stalls on changing patterns. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_integer_nearest_neighbor_scaler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 80;
    // Cycles allowed for a pixel without a result to leave the block.
    localparam int SETTLE       = 16;
    localparam int LIMIT        = 2000;
    localparam logic [inns_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef enum logic [1:0] {
        POP_ALWAYS,
        POP_HALF,
        POP_QUARTER,
        POP_MOSTLY
    } t_pop_pattern;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            push = 1'b0;
    logic                            full;
    logic [inns_pkg::CH_W-1:0]       pix_red = '0;
    logic [inns_pkg::CH_W-1:0]       pix_green = '0;
    logic [inns_pkg::CH_W-1:0]       pix_blue = '0;
    logic                            empty;
    logic                            pop = 1'b0;
    logic [inns_pkg::CH_W-1:0]       out_red;
    logic [inns_pkg::CH_W-1:0]       out_green;
    logic [inns_pkg::CH_W-1:0]       out_blue;
    logic [inns_pkg::DEST_W-1:0]     dest_x;
    logic [inns_pkg::DEST_W-1:0]     dest_y;
    logic                            run_last;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [inns_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [inns_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    int           errors;
    int           pending;
    int           idle_cycles = 0;
    t_pop_pattern pop_mode = POP_ALWAYS;
    int           pop_left = 0;

    integer_nearest_neighbor_scaler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_red       (pix_red),
        .i_green     (pix_green),
        .i_blue      (pix_blue),
        .empty       (empty),
        .pop         (pop),
        .o_out_red   (out_red),
        .o_out_green (out_green),
        .o_out_blue  (out_blue),
        .o_dest_x    (dest_x),
        .o_dest_y    (dest_y),
        .o_run_last  (run_last),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    inns_pixel_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_red       (pix_red),
        .i_green     (pix_green),
        .i_blue      (pix_blue),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_out_red   (out_red),
        .i_out_green (out_green),
        .i_out_blue  (out_blue),
        .i_dest_x    (dest_x),
        .i_dest_y    (dest_y),
        .i_run_last  (run_last),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // The receiver switches to a random stall pattern whenever its countdown runs out.
    always @(negedge clk) begin
        if (pop_left == 0) begin
            pop_mode <= t_pop_pattern'($urandom_range(0, 3));
            pop_left <= $urandom_range(8, 48);
        end else begin
            pop_left <= pop_left - 1;
        end
        case (pop_mode)
            POP_ALWAYS:  pop <= 1'b1;
            POP_HALF:    pop <= 1'($urandom_range(0, 1));
            POP_QUARTER: pop <= (pop_left[1:0] == 2'd0);
            default:     pop <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Count cycles in which no word moves on any channel.
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < LIMIT) @(negedge clk);
        $display("tb_integer_nearest_neighbor_scaler failed");
        $finish;
    end

    // Present one pixel word and hold it until it is taken.
    task automatic push_pixel(input logic [inns_pkg::CH_W-1:0] r, g, b);
        @(negedge clk);
        push      <= 1'b1;
        pix_red   <= r;
        pix_green <= g;
        pix_blue  <= b;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            @(negedge clk);
            push <= 1'b0;
        end
    endtask

    // Stop sending and wait for every predicted result to come out.
    task automatic wait_idle();
        hold_off(1);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [inns_pkg::CFG_IDX_W-1:0] idx,
                             input logic [inns_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic configure(input logic [inns_pkg::CFG_DATA_W-1:0] enl, ws, hs, bin, thr,
                             fw, fh);
        wait_idle();
        write_reg(inns_pkg::REG_ENLARGE, enl);
        write_reg(inns_pkg::REG_X_STEP, ws);
        write_reg(inns_pkg::REG_Y_STEP, hs);
        write_reg(inns_pkg::REG_BINARIZE, bin);
        write_reg(inns_pkg::REG_THRESHOLD, thr);
        write_reg(inns_pkg::REG_FRAME_WIDTH, fw);
        write_reg(inns_pkg::REG_FRAME_HEIGHT, fh);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random pixel words in bursts, with or without gaps between them.
    task automatic send_pixels(input int count, input bit with_gaps);
        int burst;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            if (burst == 0) begin
                if (with_gaps) begin
                    hold_off($urandom_range(0, 5));
                end
                burst = $urandom_range(1, 12);
            end
            push_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            burst--;
        end
        hold_off(1);
    endtask

    // Mostly small steps, now and then zero, the maximum or beyond it.
    function automatic logic [inns_pkg::CFG_DATA_W-1:0] pick_step();
        int pick;
        int step;
        pick = $urandom_range(0, 19);
        case (pick)
            0:       step = 0;
            1:       step = inns_pkg::MAX_STEP;
            2:       step = $urandom_range(inns_pkg::MAX_STEP + 1, 15);
            default: step = $urandom_range(1, 4);
        endcase
        return {9'($urandom), 4'(step)};
    endfunction

    // Mostly small frames so that they wrap often, now and then the extremes.
    function automatic logic [inns_pkg::CFG_DATA_W-1:0] pick_dim(input int small_hi);
        int pick;
        pick = $urandom_range(0, 19);
        case (pick)
            0:       return '0;
            1:       return inns_pkg::CFG_DATA_W'(inns_pkg::MAX_DIM);
            2:       return inns_pkg::CFG_DATA_W'($urandom_range(inns_pkg::MAX_DIM + 1, 8191));
            3:       return inns_pkg::CFG_DATA_W'($urandom_range(small_hi + 1,
                                                                 inns_pkg::MAX_DIM));
            default: return inns_pkg::CFG_DATA_W'($urandom_range(1, small_hi));
        endcase
    endfunction

    initial begin : stimulus
        int random_sent;
        int n;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: two by two shrink over a large frame.
        push_pixel(8'h00, 8'h00, 8'h00);
        push_pixel(8'hFF, 8'hFF, 8'hFF);
        hold_off(3);
        push_pixel(8'hAA, 8'h55, 8'hAA);
        push_pixel(8'h55, 8'hAA, 8'h55);

        // Largest tile, thresholded at zero.
        configure(1, inns_pkg::CFG_DATA_W'(inns_pkg::MAX_STEP),
                  inns_pkg::CFG_DATA_W'(inns_pkg::MAX_STEP), 1, 0, 3, 2);
        push_pixel(8'h00, 8'h01, 8'hFF);
        push_pixel(8'h80, 8'h7F, 8'h01);

        // Zero and oversized steps and frame sizes; a threshold of 255 clears all.
        configure(1, 0, 15, 1, 255, 0, 8191);
        push_pixel(8'hFF, 8'hFE, 8'h00);
        push_pixel(8'hFF, 8'hFF, 8'hFF);

        // Shrink by three across a width of seven drops the partial edge block.
        // The row left behind lies beyond the new frame height.
        configure(0, 3, 1, 0, 127, 7, 2);
        write_reg(REG_NONE, '1);
        @(negedge clk);
        cfg_valid <= 1'b0;
        repeat (9) push_pixel(8'($urandom), 8'($urandom), 8'($urandom));

        // Steps and width cut down part way through a frame.
        configure(0, 1, 1, 1, 100, 2, 2);
        push_pixel(8'd100, 8'd101, 8'd99);
        push_pixel(8'd101, 8'd100, 8'd255);
        push_pixel(8'd0, 8'd255, 8'd100);
        push_pixel(8'd255, 8'd0, 8'd101);

        // Random phases, each with fresh settings.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            configure({12'($urandom), 1'($urandom)}, pick_step(), pick_step(),
                      {12'($urandom), 1'($urandom)}, {5'($urandom), 8'($urandom)},
                      pick_dim(9), pick_dim(6));
            n = $urandom_range(4, 20);
            send_pixels(n, $urandom_range(0, 2) != 0);
            random_sent += n;
        end

        wait_idle();
        if (errors == 0 && pending == 0) begin
            $display("tb_integer_nearest_neighbor_scaler passed");
        end else begin
            $display("tb_integer_nearest_neighbor_scaler failed");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/inns_pkg.sv
hw/rtl/inns_front.sv
hw/rtl/inns_queue.sv
hw/rtl/inns_back.sv
hw/rtl/integer_nearest_neighbor_scaler.sv
verif/inns_pixel_checker.sv
verif/tb_integer_nearest_neighbor_scaler.sv
